// ----- rtl/core/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and helpers of the stable priority task queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int PRIO_BITS   = 8;

  localparam int ID_W     = 4;
  localparam int CMD_W    = 3;
  localparam int IN_PRIO_W = 8;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 5;
  localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);

  localparam int PRIO_EXT = (PRIO_BITS > IN_PRIO_W) ? PRIO_BITS : IN_PRIO_W;
  localparam int CNT_EXT  = (CNT_W > OCC_W) ? CNT_W : OCC_W;

  // commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd4;

  // result status
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DUP  = 2'd2;

  // operations broadcast to the cells
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_SHIFT  = 2'd3;

  typedef logic [PRIO_BITS-1:0] prio_t;
  typedef logic [ID_W-1:0]      id_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    logic  valid;
    id_t   id;
    prio_t prio;
  } slot_t;

  typedef struct packed {
    logic [1:0] op;
    id_t        id;
    prio_t      prio;
  } cell_ctl_t;

  function automatic prio_t to_prio(input logic [IN_PRIO_W-1:0] p);
    logic [PRIO_EXT-1:0] t;
    t = PRIO_EXT'(p);
    return t[PRIO_BITS-1:0];
  endfunction

  function automatic logic [IN_PRIO_W-1:0] from_prio(input prio_t p);
    logic [PRIO_EXT-1:0] t;
    t = PRIO_EXT'(p);
    return t[IN_PRIO_W-1:0];
  endfunction

  function automatic logic [OCC_W-1:0] to_occ(input cnt_t c);
    logic [CNT_EXT-1:0] t;
    t = CNT_EXT'(c);
    return t[OCC_W-1:0];
  endfunction

endpackage

// ----- rtl/core/spq_if.sv -----
// ----------------------------------------------------------------------------
// spq channel interfaces
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface spq_in_if
  import spq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [ID_W-1:0]      task_id;
  logic [IN_PRIO_W-1:0] prio;

  modport source (output valid, cmd, task_id, prio, input ready);
  modport sink   (input valid, cmd, task_id, prio, output ready);
endinterface

interface spq_out_if
  import spq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [ID_W-1:0]      out_id;
  logic [IN_PRIO_W-1:0] out_prio;
  logic [OCC_W-1:0]     occupancy;
  logic                 last;

  modport source (output valid, status, out_id, out_prio, occupancy, last, input ready);
  modport sink   (input valid, status, out_id, out_prio, occupancy, last, output ready);
endinterface

// ----- rtl/core/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One queue slot: compares against the broadcast entry and takes its next
// value from itself, the broadcast entry or a neighbor.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  slot_t     left,
  input  logic      ge_left,
  input  slot_t     right,
  input  logic      hit_in,
  output slot_t     slot,
  output logic      ge,
  output logic      hit_out
);

  logic  valid_r, valid_nxt;
  id_t   id_r, id_nxt;
  prio_t prio_r, prio_nxt;
  logic  match;

  assign ge      = valid_r && (prio_r >= ctl.prio);
  assign match   = valid_r && (id_r == ctl.id);
  assign hit_out = hit_in | match;

  assign slot.valid = valid_r;
  assign slot.id    = id_r;
  assign slot.prio  = prio_r;

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    prio_nxt  = prio_r;
    case (ctl.op)
      OP_INSERT: begin
        if (!ge) begin
          if (ge_left) begin
            // first slot behind all entries of equal or higher priority
            valid_nxt = 1'b1;
            id_nxt    = ctl.id;
            prio_nxt  = ctl.prio;
          end else begin
            valid_nxt = left.valid;
            id_nxt    = left.id;
            prio_nxt  = left.prio;
          end
        end
      end
      OP_REMOVE: begin
        if (hit_out) begin
          valid_nxt = right.valid;
          id_nxt    = right.id;
          prio_nxt  = right.prio;
        end
      end
      OP_SHIFT: begin
        valid_nxt = right.valid;
        id_nxt    = right.id;
        prio_nxt  = right.prio;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
  end

endmodule

// ----- rtl/core/stable_priority_task_queue.sv -----
// ----------------------------------------------------------------------------
// stable_priority_task_queue
// Priority wait queue of task ids held in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Each command item is accepted in S_IDLE and then executed in S_EXEC, in
// which every cell compares against the command at once and, where the
// command moves entries, takes a value from a neighbor, so insert, remove,
// pop and peek all settle in S_EXEC. A flush goes from S_EXEC to S_FLUSH and
// drains one entry per cycle from the head cell while the output is free.
// The single output register sets the pace under back-pressure: the
// execute and drain cycles wait while a result is still not taken.
module stable_priority_task_queue
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_if,
  spq_out_if.source out_if
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CMD_W-1:0] cmd_r;
  id_t              id_r;
  prio_t            prio_r;
  cnt_t             count_r, count_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]    status_r, status_nxt;
  id_t                  oid_r, oid_nxt;
  logic [IN_PRIO_W-1:0] oprio_r, oprio_nxt;
  logic [OCC_W-1:0]     occ_r, occ_nxt;
  logic                 last_r, last_nxt;

  cell_ctl_t ctl;
  logic [1:0] op;
  slot_t     slots [MAX_ENTRIES];
  logic      ge    [MAX_ENTRIES];
  logic      hit   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_vec;

  logic in_fire, out_free, emit, any_hit, full;
  slot_t head;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;

  assign ctl.op   = op;
  assign ctl.id   = id_r;
  assign ctl.prio = prio_r;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      slot_t left_s, right_s;
      logic  ge_l, hit_l;
      if (gi == 0) begin : g_first
        assign left_s = '0;
        assign ge_l   = 1'b1;
        assign hit_l  = 1'b0;
      end else begin : g_mid
        assign left_s = slots[gi-1];
        assign ge_l   = ge[gi-1];
        assign hit_l  = hit[gi-1];
      end
      if (gi == MAX_ENTRIES - 1) begin : g_tail
        assign right_s = '0;
      end else begin : g_body
        assign right_s = slots[gi+1];
      end
      spq_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .left    (left_s),
        .ge_left (ge_l),
        .right   (right_s),
        .hit_in  (hit_l),
        .slot    (slots[gi]),
        .ge      (ge[gi]),
        .hit_out (hit[gi])
      );
      assign valid_vec[gi] = slots[gi].valid;
    end
  endgenerate

  assign head    = slots[0];
  assign any_hit = hit[MAX_ENTRIES-1];
  assign full    = (count_r == CNT_W'(MAX_ENTRIES));

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    op         = OP_HOLD;
    emit       = 1'b0;
    status_nxt = STAT_MISS;
    oid_nxt    = '0;
    oprio_nxt  = '0;
    occ_nxt    = to_occ(count_r);
    last_nxt   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          emit      = 1'b1;
          case (cmd_r)
            CMD_INSERT: begin
              if (any_hit) begin
                status_nxt = STAT_DUP;
              end else if (!full) begin
                op         = OP_INSERT;
                status_nxt = STAT_OK;
                count_nxt  = count_r + CNT_W'(1);
                occ_nxt    = to_occ(count_nxt);
              end
            end
            CMD_REMOVE: begin
              if (any_hit) begin
                op         = OP_REMOVE;
                status_nxt = STAT_OK;
                count_nxt  = count_r - CNT_W'(1);
                occ_nxt    = to_occ(count_nxt);
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (count_r != '0) begin
                status_nxt = STAT_OK;
                oid_nxt    = head.id;
                oprio_nxt  = from_prio(head.prio);
                if (cmd_r == CMD_POP) begin
                  op        = OP_SHIFT;
                  count_nxt = count_r - CNT_W'(1);
                  occ_nxt   = to_occ(count_nxt);
                end
              end
            end
            CMD_FLUSH: begin
              if (count_r != '0) begin
                // drain starts in S_FLUSH
                emit      = 1'b0;
                state_nxt = S_FLUSH;
              end
            end
            default: begin
              status_nxt = STAT_MISS;
            end
          endcase
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          emit       = 1'b1;
          op         = OP_SHIFT;
          status_nxt = STAT_OK;
          oid_nxt    = head.id;
          oprio_nxt  = from_prio(head.prio);
          count_nxt  = count_r - CNT_W'(1);
          occ_nxt    = to_occ(count_nxt);
          last_nxt   = (count_r == CNT_W'(1));
          if (last_nxt) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_if.cmd;
      id_r   <= in_if.task_id;
      prio_r <= to_prio(in_if.prio);
    end
    if (emit) begin
      status_r <= status_nxt;
      oid_r    <= oid_nxt;
      oprio_r  <= oprio_nxt;
      occ_r    <= occ_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.status    = status_r;
  assign out_if.out_id    = oid_r;
  assign out_if.out_prio  = oprio_r;
  assign out_if.occupancy = occ_r;
  assign out_if.last      = last_r;

  // occupied cells always form a prefix of the row, as many as the count
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == 32'(count_r))
    else $error("cell valid bits disagree with entry count");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + MAX_ENTRIES'(1))) == '0)
    else $error("occupied cells are not a prefix");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH && emit && last_nxt) |=> (count_r == '0))
    else $error("queue not empty after final flush item");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (op == OP_HOLD || !in_if.ready))
    else $error("cells changed while a new item could enter");

  generate
    for (gi = 1; gi < MAX_ENTRIES; gi++) begin : g_sorted
      a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (slots[gi].valid) |-> (slots[gi-1].prio >= slots[gi].prio))
        else $error("queue order broken");
    end
  endgenerate

endmodule
